// File: rtl/slfp_pkg.sv
// Package for the sync/length frame parser.
// Holds parser phases, result kinds, register indexes and the result record.
// No dependencies.
package slfp_pkg;

  typedef enum logic [2:0] {
    PH_SYNC0 = 3'd0,
    PH_SYNC1 = 3'd1,
    PH_LEN0  = 3'd2,
    PH_LEN1  = 3'd3,
    PH_ID    = 3'd4,
    PH_PAY   = 3'd5,
    PH_HUNT0 = 3'd6,
    PH_HUNT1 = 3'd7
  } phase_t;

  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_IDONLY  = 3'd1;
  localparam logic [2:0] KIND_EMPTY   = 3'd2;
  localparam logic [2:0] KIND_BADSYNC = 3'd3;
  localparam logic [2:0] KIND_BADLEN  = 3'd4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 2'd2;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'h28;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h06;
  localparam logic [15:0] MAX_LENGTH_RST  = 16'hFFFF;
  localparam logic [15:0] ID_BYTES        = 16'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] msg_id;
    logic [7:0]  payload_byte;
    logic        last;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/slfp_front.sv
// Front part: configuration registers and the per-byte parser state machine.
// Classifies each accepted byte and pushes at most one result into the queue.
// Depends on slfp_pkg.
module slfp_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [slfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slfp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  input  slfp_pkg::q_status_t             q_status,
  output logic                            push_valid,
  output slfp_pkg::res_t                  push_data
);

  logic [7:0]       sync_first_r;
  logic [7:0]       sync_second_r;
  logic [15:0]      max_length_r;
  slfp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      cnt_r, cnt_nxt;
  logic [31:0]      id_r, id_nxt;

  logic        accept;
  logic        is_first;
  logic        is_second;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;
  logic [31:0] id_merged;
  logic        len_bad;

  assign in_stall  = q_status.full;
  assign accept    = in_valid && !q_status.full;
  assign is_first  = (in_data_byte == sync_first_r);
  assign is_second = (in_data_byte == sync_second_r);
  assign len_full  = {in_data_byte, len_r[7:0]};
  assign cnt_inc   = cnt_r + 16'd1;
  assign id_merged = id_r | ({24'd0, in_data_byte} << {cnt_r[1:0], 3'b000});
  assign len_bad   = (len_full < slfp_pkg::ID_BYTES) || (len_full > max_length_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= slfp_pkg::SYNC_FIRST_RST;
      sync_second_r <= slfp_pkg::SYNC_SECOND_RST;
      max_length_r  <= slfp_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        slfp_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata[7:0];
        slfp_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_wdata[7:0];
        slfp_pkg::CFG_MAX_LENGTH:  max_length_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= slfp_pkg::PH_SYNC0;
      len_r   <= '0;
      cnt_r   <= '0;
      id_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      id_r    <= id_nxt;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    id_nxt    = id_r;
    case (phase_r)
      slfp_pkg::PH_SYNC0: begin
        phase_nxt = is_first ? slfp_pkg::PH_SYNC1 : slfp_pkg::PH_HUNT0;
      end
      slfp_pkg::PH_SYNC1: begin
        if (is_second) phase_nxt = slfp_pkg::PH_LEN0;
        else if (is_first) phase_nxt = slfp_pkg::PH_HUNT1;
        else phase_nxt = slfp_pkg::PH_HUNT0;
      end
      slfp_pkg::PH_HUNT0: begin
        if (is_first) phase_nxt = slfp_pkg::PH_HUNT1;
      end
      slfp_pkg::PH_HUNT1: begin
        if (is_second) phase_nxt = slfp_pkg::PH_LEN0;
        else if (is_first) phase_nxt = slfp_pkg::PH_HUNT1;
        else phase_nxt = slfp_pkg::PH_HUNT0;
      end
      slfp_pkg::PH_LEN0: begin
        len_nxt   = {8'd0, in_data_byte};
        phase_nxt = slfp_pkg::PH_LEN1;
      end
      slfp_pkg::PH_LEN1: begin
        len_nxt = len_full;
        cnt_nxt = '0;
        id_nxt  = '0;
        if (len_full == 16'd0 || len_bad) phase_nxt = slfp_pkg::PH_SYNC0;
        else phase_nxt = slfp_pkg::PH_ID;
      end
      slfp_pkg::PH_ID: begin
        id_nxt  = id_merged;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= slfp_pkg::ID_BYTES) begin
          phase_nxt = (len_r <= slfp_pkg::ID_BYTES) ? slfp_pkg::PH_SYNC0 : slfp_pkg::PH_PAY;
        end
      end
      slfp_pkg::PH_PAY: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= len_r) phase_nxt = slfp_pkg::PH_SYNC0;
      end
      default: phase_nxt = slfp_pkg::PH_SYNC0;
    endcase
  end

  // outputs
  always_comb begin
    push_valid             = 1'b0;
    push_data.kind         = slfp_pkg::KIND_PAYLOAD;
    push_data.msg_id       = '0;
    push_data.payload_byte = '0;
    push_data.last         = 1'b1;
    case (phase_r)
      slfp_pkg::PH_SYNC0: begin
        push_valid     = accept && !is_first;
        push_data.kind = slfp_pkg::KIND_BADSYNC;
      end
      slfp_pkg::PH_SYNC1: begin
        push_valid     = accept && !is_second;
        push_data.kind = slfp_pkg::KIND_BADSYNC;
      end
      slfp_pkg::PH_LEN1: begin
        push_valid     = accept && (len_full == 16'd0 || len_bad);
        push_data.kind = (len_full == 16'd0) ? slfp_pkg::KIND_EMPTY : slfp_pkg::KIND_BADLEN;
      end
      slfp_pkg::PH_ID: begin
        push_valid       = accept && (cnt_inc >= slfp_pkg::ID_BYTES) &&
                           (len_r <= slfp_pkg::ID_BYTES);
        push_data.kind   = slfp_pkg::KIND_IDONLY;
        push_data.msg_id = id_merged;
      end
      slfp_pkg::PH_PAY: begin
        push_valid             = accept;
        push_data.kind         = slfp_pkg::KIND_PAYLOAD;
        push_data.msg_id       = id_r;
        push_data.payload_byte = in_data_byte;
        push_data.last         = (cnt_inc >= len_r);
      end
      default: push_valid = 1'b0;
    endcase
  end

endmodule

// File: rtl/slfp_queue.sv
// Short result queue between the parser and the output stage.
// Register array with wrap-around pointers and an occupancy count.
// Depends on slfp_pkg.
module slfp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  slfp_pkg::res_t      push_data,
  input  logic                pop,
  output slfp_pkg::res_t      pop_data,
  output slfp_pkg::q_status_t q_status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  slfp_pkg::res_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_status.full  = (count_r == FULL_CNT);
  assign q_status.empty = (count_r == '0);
  assign do_push        = push_valid && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_data       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop) rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: rtl/slfp_back.sv
// Back part: output register that drains the queue onto the result channel.
// Holds a result while the receiver stalls.
// Depends on slfp_pkg.
module slfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  slfp_pkg::q_status_t q_status,
  input  slfp_pkg::res_t      pop_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_kind,
  output logic signed [31:0]  out_msg_id,
  output logic [7:0]          out_payload_byte,
  output logic                out_last
);

  logic           valid_r, valid_nxt;
  slfp_pkg::res_t res_r;

  assign pop       = !q_status.empty && (!valid_r || !out_stall);
  assign valid_nxt = pop || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= pop_data;
  end

  assign out_valid        = valid_r;
  assign out_kind         = res_r.kind;
  assign out_msg_id       = res_r.msg_id;
  assign out_payload_byte = res_r.payload_byte;
  assign out_last         = res_r.last;

endmodule

// File: rtl/sync_length_frame_parser.sv
// Top level of the sync/length frame parser: parser front, result queue, output stage.
// Depends on slfp_pkg, slfp_front, slfp_queue and slfp_back.
//
//   port group   direction  handshake             payload
//   in_*         in         in_valid / in_stall   in_data_byte
//   out_*        out        out_valid / out_stall out_kind, out_msg_id, out_payload_byte, out_last
//   cfg_*        in         cfg_we                cfg_index, cfg_wdata
//
// One byte is taken per cycle while in_stall is low; any result goes through the queue and the output register.
// The parser state machine sets that rate: every byte is classified in the cycle it arrives.
// rst_n is synchronous: phase, counters, queue and output valid clear, registers reload.
// in_stall rises only when the QUEUE_DEPTH-entry queue is full; out_stall backs up the queue.
module sync_length_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [slfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slfp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_kind,
  output logic signed [31:0]              out_msg_id,
  output logic [7:0]                      out_payload_byte,
  output logic                            out_last
);

  slfp_pkg::q_status_t q_status;
  slfp_pkg::res_t      push_data;
  slfp_pkg::res_t      pop_data;
  logic                push_valid;
  logic                pop;

  slfp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .q_status     (q_status),
    .push_valid   (push_valid),
    .push_data    (push_data)
  );

  slfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .pop_data   (pop_data),
    .q_status   (q_status)
  );

  slfp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .pop_data         (pop_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_msg_id       (out_msg_id),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last)
  );

endmodule

// File: rtl/slfp_checker.sv
// Port-level checks for the sync/length frame parser, bound to its top level.
// Depends on slfp_pkg and sync_length_frame_parser.
module slfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_kind,
  input logic signed [31:0] out_msg_id,
  input logic [7:0]         out_payload_byte,
  input logic               out_last
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid not cleared by reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_msg_id) &&
      $stable(out_payload_byte) && $stable(out_last))
    else $error("stalled result changed");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= slfp_pkg::KIND_BADLEN)
    else $error("unknown result kind");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != slfp_pkg::KIND_PAYLOAD |-> out_last && out_payload_byte == 8'd0)
    else $error("status result without last or with payload");

  a_status_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == slfp_pkg::KIND_EMPTY || out_kind == slfp_pkg::KIND_BADSYNC ||
      out_kind == slfp_pkg::KIND_BADLEN) |-> out_msg_id == 32'sd0)
    else $error("status result carries a message id");

endmodule

bind sync_length_frame_parser slfp_checker u_slfp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_msg_id       (out_msg_id),
  .out_payload_byte (out_payload_byte),
  .out_last         (out_last)
);
